// ===== design/max_tracking_two_stack_queue_defines.svh =====
// Assertion macros for the max-tracking two-stack queue.
// Included by the modules that carry concurrent assertions; expects clk and arst_n in scope.
`ifndef MAX_TRACKING_TWO_STACK_QUEUE_DEFINES_SVH
`define MAX_TRACKING_TWO_STACK_QUEUE_DEFINES_SVH

// checked only outside reset
`define MTQ_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MTQ_CHECK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mtq_pkg.sv =====
// Shared types and constants for the max-tracking two-stack queue.
// No dependencies.
package mtq_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef struct packed {
		logic              action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               queue_empty;
		logic signed [31:0] max_value;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] maxv;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

// ===== design/max_tracking_two_stack_queue.sv =====
// Max-tracking FIFO queue from two shift-register stacks with running maxima.
// Uses mtq_pkg, mtq_cell and max_tracking_two_stack_queue_defines.svh.
//
// Usage:
//   req channel (req_valid, req_stall, req): action 0 enqueues req.value,
//   action 1 dequeues the oldest element. rsp channel (rsp_valid, rsp_stall,
//   rsp): one result per request with status, queue_empty and the maximum.
// Timing:
//   Enqueue, a failed operation, or a dequeue with a non-empty out-stack goes
//   to the done state, which loads the output register. A dequeue that finds
//   the out-stack empty passes first through the transfer state, where the N
//   in-stack elements move one per cycle onto the out-stack top, then the pop
//   state and the done state. Each element moves once.
//   The next request is taken once the result is in the output register.
// Reset:
//   arst_n clears both fill counts, the control state and rsp_valid.
//   Stack contents are not cleared; only slots below a count are read.
// Stall:
//   A stalled result holds in the output register; a following result
//   waits in its final state and req_stall stays high meanwhile.
`include "max_tracking_two_stack_queue_defines.svh"

module max_tracking_two_stack_queue
	import mtq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_XFER = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] in_cnt_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [1:0]       status_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	entry_t    in_slot  [STACK_DEPTH];
	entry_t    out_slot [STACK_DEPTH];
	entry_t    in_new;
	entry_t    out_new;
	cell_ctl_t in_ctl;
	cell_ctl_t out_ctl;

	logic             req_take;
	logic             in_full;
	logic             in_any;
	logic             out_any;
	logic             rsp_load;
	logic signed [31:0] cur_max;
	logic [CNT_W:0]   total;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign in_full   = (in_cnt_q == CNT_W'(STACK_DEPTH));
	assign in_any    = (in_cnt_q != '0);
	assign out_any   = (out_cnt_q != '0);
	assign total     = {1'b0, in_cnt_q} + {1'b0, out_cnt_q};

	always_comb begin
		in_new.value  = req.value;
		in_new.maxv   = (in_any && in_slot[0].maxv > req.value) ? in_slot[0].maxv : req.value;
		out_new.value = in_slot[0].value;
		out_new.maxv  = (out_any && out_slot[0].maxv > in_slot[0].value) ?
			out_slot[0].maxv : in_slot[0].value;

		in_ctl.push  = req_take && (req.action == ACT_ENQ) && !in_full;
		in_ctl.pop   = (state_q == S_XFER);
		out_ctl.push = (state_q == S_XFER);
		out_ctl.pop  = (req_take && (req.action == ACT_DEQ) && out_any) || (state_q == S_POP);
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cells
		entry_t in_top, in_bot, out_top, out_bot;

		if (i == 0) begin : g_head
			assign in_top  = in_new;
			assign out_top = out_new;
		end else begin : g_body
			assign in_top  = in_slot[i-1];
			assign out_top = out_slot[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_tail
			assign in_bot  = in_slot[i];
			assign out_bot = out_slot[i];
		end else begin : g_inner
			assign in_bot  = in_slot[i+1];
			assign out_bot = out_slot[i+1];
		end

		mtq_cell u_in_cell (
			.clk         (clk),
			.ctl         (in_ctl),
			.from_top    (in_top),
			.from_bottom (in_bot),
			.slot        (in_slot[i])
		);

		mtq_cell u_out_cell (
			.clk         (clk),
			.ctl         (out_ctl),
			.from_top    (out_top),
			.from_bottom (out_bot),
			.slot        (out_slot[i])
		);
	end

	always_comb begin
		priority if (in_any && out_any) begin
			cur_max = (in_slot[0].maxv > out_slot[0].maxv) ? in_slot[0].maxv : out_slot[0].maxv;
		end else if (in_any) begin
			cur_max = in_slot[0].maxv;
		end else if (out_any) begin
			cur_max = out_slot[0].maxv;
		end else begin
			cur_max = '0;
		end
	end

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			status_q  <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						state_q  <= S_DONE;
						status_q <= ST_OK;
						if (req.action == ACT_ENQ) begin
							if (in_full) begin
								status_q <= ST_OVERFLOW;
							end else begin
								in_cnt_q <= in_cnt_q + 1'b1;
							end
						end else if (!in_any && !out_any) begin
							status_q <= ST_UNDERFLOW;
						end else if (!out_any) begin
							state_q <= S_XFER;
						end else begin
							out_cnt_q <= out_cnt_q - 1'b1;
						end
					end
				end
				S_XFER: begin
					in_cnt_q  <= in_cnt_q - 1'b1;
					out_cnt_q <= out_cnt_q + 1'b1;
					if (in_cnt_q == CNT_W'(1)) begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					out_cnt_q <= out_cnt_q - 1'b1;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.queue_empty <= !in_any && !out_any;
			rsp_q.max_value   <= cur_max;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`MTQ_CHECK(a_cnt_bound,
		(in_cnt_q <= CNT_W'(STACK_DEPTH)) && (out_cnt_q <= CNT_W'(STACK_DEPTH)),
		"stack fill count beyond depth")
	`MTQ_CHECK(a_xfer_src, (state_q == S_XFER) |-> in_any, "transfer with empty in-stack")
	`MTQ_CHECK(a_xfer_keep, (state_q == S_XFER) |=> (total == $past(total)),
		"element count changed during transfer")
	`MTQ_CHECK(a_empty_max, (rsp_valid && rsp.queue_empty) |-> (rsp.max_value == 0),
		"empty queue reports nonzero maximum")

endmodule

// ===== design/mtq_cell.sv =====
// One stack slot: a value and its running maximum.
// Shifts toward the bottom on push and toward the top on pop. Uses mtq_pkg.
module mtq_cell
	import mtq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    from_top,
	input  entry_t    from_bottom,
	output entry_t    slot
);

	entry_t slot_q;

	always_ff @(posedge clk) begin
		priority if (ctl.push) begin
			slot_q <= from_top;
		end else if (ctl.pop) begin
			slot_q <= from_bottom;
		end else begin
			slot_q <= slot_q;
		end
	end

	assign slot = slot_q;

endmodule

// ===== dv/tb_max_tracking_two_stack_queue.sv =====
// Testbench for max_tracking_two_stack_queue: directed edge cases, back-pressure, random traffic.
// Predicts status, empty flag and running maximum per transfer and checks every result in order.
// Depends on mtq_pkg and the max_tracking_two_stack_queue RTL.
module tb_max_tracking_two_stack_queue
	import mtq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 40;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	max_tracking_two_stack_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// queue prediction state
	logic signed [31:0] in_val [STACK_DEPTH];
	logic signed [31:0] in_mx  [STACK_DEPTH];
	logic signed [31:0] out_mx [STACK_DEPTH];
	int                 in_fill  = 0;
	int                 out_fill = 0;

	rsp_t pending_results[$];
	rsp_t want;
	int   mismatch_count = 0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	function automatic rsp_t queue_model_apply(req_t op);
		rsp_t               r;
		logic signed [31:0] v;
		r.status = ST_OK;
		if (op.action == ACT_ENQ) begin
			if (in_fill >= STACK_DEPTH) begin
				r.status = ST_OVERFLOW;
			end else begin
				in_val[in_fill] = op.value;
				in_mx[in_fill]  = (in_fill > 0 && in_mx[in_fill-1] > op.value) ?
				                  in_mx[in_fill-1] : op.value;
				in_fill++;
			end
		end else if (in_fill == 0 && out_fill == 0) begin
			r.status = ST_UNDERFLOW;
		end else begin
			if (out_fill == 0) begin
				while (in_fill > 0) begin
					in_fill--;
					v = in_val[in_fill];
					out_mx[out_fill] = (out_fill > 0 && out_mx[out_fill-1] > v) ?
					                   out_mx[out_fill-1] : v;
					out_fill++;
				end
			end
			out_fill--;
		end
		r.queue_empty = (in_fill == 0 && out_fill == 0);
		if (in_fill == 0 && out_fill == 0)
			r.max_value = '0;
		else if (in_fill == 0)
			r.max_value = out_mx[out_fill-1];
		else if (out_fill == 0)
			r.max_value = in_mx[in_fill-1];
		else
			r.max_value = (in_mx[in_fill-1] > out_mx[out_fill-1]) ?
			              in_mx[in_fill-1] : out_mx[out_fill-1];
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2, 3, 4: return $signed(32'($urandom_range(20))) - 32'sd10;
			default: return $urandom;
		endcase
	endfunction

	task automatic issue_queue_op(input logic act, input logic signed [31:0] val);
		req_t op;
		op.action = act;
		op.value  = val;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= op;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(queue_model_apply(op));
	endtask

	task automatic wait_queue_drained();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_edges();
		issue_queue_op(ACT_DEQ, 32'sh1234_5678);   // underflow on empty queue
		issue_queue_op(ACT_ENQ, 32'sh8000_0000);
		issue_queue_op(ACT_DEQ, '0);
		for (int i = 0; i < STACK_DEPTH; i++) begin
			case (i)
				0:       issue_queue_op(ACT_ENQ, -32'sd1);
				3:       issue_queue_op(ACT_ENQ, 32'sh7fff_ffff);
				5:       issue_queue_op(ACT_ENQ, 32'sh8000_0000);
				8:       issue_queue_op(ACT_ENQ, '0);
				default: issue_queue_op(ACT_ENQ, $signed(32'(100 - 7 * i)));
			endcase
		end
		issue_queue_op(ACT_ENQ, 32'sh0000_0055);   // overflow, in-stack full
		issue_queue_op(ACT_DEQ, '1);               // moves whole in-stack
		issue_queue_op(ACT_ENQ, -32'sd5);
		wait_queue_drained();
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
		int sent;
		int kind;
		int burst;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_items) begin
			kind  = $urandom_range(9);
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst; i++) begin
				if (kind < 4)
					issue_queue_op(ACT_ENQ, pick_value());
				else if (kind < 8)
					issue_queue_op(ACT_DEQ, $urandom);
				else
					issue_queue_op(logic'($urandom_range(1)), pick_value());
				sent++;
			end
		end
		wait_queue_drained();
	endtask

	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests++;
		for (int i = 0; i < 14; i++)
			issue_queue_op((i % 4 == 3) ? ACT_DEQ : ACT_ENQ, pick_value());
		wait_queue_drained();
	endtask

	// receiver stall, with one long hold-off in the back-pressure test
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = RX_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual %p", $time, rsp);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
					         $time, want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.queue_empty !== want.queue_empty) begin
					$display("%0t: queue_empty expected %0b actual %0b",
					         $time, want.queue_empty, rsp.queue_empty);
					mismatch_count++;
				end
				if (rsp.max_value !== want.max_value) begin
					$display("%0t: max_value expected %0d actual %0d",
					         $time, want.max_value, rsp.max_value);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_random_traffic(8, 72, 590);
		test_random_traffic(72, 8, 590);
		test_random_traffic(0, 0, 590);
		test_output_backpressure();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end

endmodule
